### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands on the clk and rst of the including module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hdl/pcb_pkg.sv
// ---------------------------------------------------------------------------
// pcb_pkg
// Shared types and constants of the particle cell binning block.
// ---------------------------------------------------------------------------
package pcb_pkg;

  localparam int POS_W   = 32;
  localparam int BOX_W   = 31;
  localparam int INV_W   = 33;
  localparam int CPS_W   = 5;
  localparam int CFG_W   = 33;
  localparam int CFG_IDX_W = 2;
  localparam int CIDX_W  = 12;
  localparam int COUNT_W = 17;
  localparam int SLOT_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BOX        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_SIDE = 2'd2;

  localparam logic [BOX_W-1:0] BOX_LENGTH_RST     = 31'd65536;
  localparam logic [INV_W-1:0] INV_BOX_RST        = 33'd65536;
  localparam logic [CPS_W-1:0] CELLS_PER_SIDE_RST = 5'd16;

  // Pass selector codes.
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_CHECK,
    ST_IDX1,
    ST_IDX2,
    ST_UPDATE
  } state_t;

endpackage

### hdl/particle_cell_binning_top.sv
// ---------------------------------------------------------------------------
// particle_cell_binning_top: one item at a time; the result register is loaded in ST_UPDATE
// once the output is free, and only then is the next item taken. Each item makes a single
// read-modify-write pass through the cell count and cell fill memories, behind a per-axis
// scaling datapath. After reset a clearing pass zeroes all MAX_SIDE**3 cells (4096 at the
// default) of both memories; no input beat is taken meanwhile, configuration writes are.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_cell_binning_top #(
  parameter int MAX_SIDE      = 16,
  parameter int MAX_PARTICLES = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic signed [pcb_pkg::POS_W-1:0] pos_x,
  input  logic signed [pcb_pkg::POS_W-1:0] pos_y,
  input  logic signed [pcb_pkg::POS_W-1:0] pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcb_pkg::CIDX_W-1:0]    cell_index,
  output logic [pcb_pkg::COUNT_W-1:0]   cell_count,
  output logic [pcb_pkg::SLOT_W-1:0]    list_slot,
  output logic [pcb_pkg::SLOT_W-1:0]    particle_index,
  output logic [pcb_pkg::COUNT_W-1:0]   total_counted,
  output logic                          out_of_range
);
  import pcb_pkg::*;

  localparam int NCELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW     = $clog2(NCELLS);
  localparam int SW     = $clog2(MAX_SIDE + 1);
  localparam int CCW    = $clog2(MAX_SIDE);
  localparam int CW     = $clog2(MAX_PARTICLES + 1);
  localparam int QH_W   = POS_W + SW;
  localparam int PLO_W  = POS_W + 17;
  localparam int PHI_W  = POS_W + INV_W - 17;
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_PARTICLES);
  localparam logic [CW-1:0] IDX_MAX   = CW'(MAX_PARTICLES - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);

  // Configuration registers.
  logic [BOX_W-1:0] box_length;
  logic [INV_W-1:0] inv_box;
  logic [CPS_W-1:0] cells_per_side;
  logic [SW-1:0]    side;

  // Control.
  state_t        state, state_next;
  logic [AW-1:0] clr_addr;
  logic          out_load;

  // Per-axis datapath, one lane per axis.
  logic [POS_W-1:0] pos_in    [3];
  logic [POS_W-1:0] mag_in    [3];
  logic [POS_W-1:0] mag       [3];
  logic             neg       [3];
  logic [PLO_W-1:0] p_lo      [3];
  logic [PHI_W-1:0] p_hi      [3];
  logic [63:0]      prod      [3];
  logic [QH_W-1:0]  q_hi      [3];
  logic [SW-1:0]    q_lo      [3];
  logic [QH_W-1:0]  lo_scaled [3];
  logic [QH_W:0]    q_sum     [3];
  logic [CCW-1:0]   coord     [3];
  logic             ax_ok     [3];
  logic             op;
  logic             item_ok;

  // Cell index and memories.
  logic [AW-1:0] idx_part;
  logic [AW-1:0] idx_comb;
  logic [AW-1:0] idx;
  logic [CW-1:0] count_mem [NCELLS];
  logic [CW-1:0] fill_mem  [NCELLS];
  logic [CW-1:0] cnt_rd;
  logic [CW-1:0] fill_rd;
  logic          cnt_we;
  logic          fill_we;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] cnt_wdata;
  logic [CW-1:0] fill_wdata;

  logic [CW-1:0] counted_total;
  logic [CW-1:0] placed_total;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] counted_inc;
  logic [CW-1:0] placed_inc;
  logic [CW-1:0] slot_cap;
  logic [CW-1:0] placed_cap;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      box_length     <= BOX_LENGTH_RST;
      inv_box        <= INV_BOX_RST;
      cells_per_side <= CELLS_PER_SIDE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOX_LENGTH:     box_length     <= cfg_data[BOX_W-1:0];
        REG_INV_BOX:        inv_box        <= cfg_data[INV_W-1:0];
        REG_CELLS_PER_SIDE: cells_per_side <= cfg_data[CPS_W-1:0];
        default: ;
      endcase
    end
  end

  // A side beyond the grid behaves as the full grid.
  assign side = (int'(cells_per_side) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(cells_per_side);

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    cnt_we     = 1'b0;
    fill_we    = 1'b0;
    wr_addr    = idx;
    cnt_wdata  = cnt_inc;
    fill_wdata = fill_inc;
    case (state)
      ST_CLEAR: begin
        cnt_we     = 1'b1;
        fill_we    = 1'b1;
        wr_addr    = clr_addr;
        cnt_wdata  = '0;
        fill_wdata = '0;
        if (clr_addr == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_CHECK;
      ST_CHECK: state_next = ST_IDX1;
      ST_IDX1:  state_next = ST_IDX2;
      ST_IDX2:  state_next = ST_UPDATE;
      ST_UPDATE: begin
        // Outside the clearing pass the memories are written only together with the result beat.
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          cnt_we     = item_ok && (op == OP_COUNT);
          fill_we    = item_ok && (op == OP_PLACE);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- per-axis scaling ----
  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // A coordinate equal to the box side wraps to the origin.
      if (pos_in[a] == {1'b0, box_length}) begin
        mag_in[a] = '0;
      end else if (pos_in[a][POS_W-1]) begin
        mag_in[a] = ~pos_in[a] + 1'b1;
      end else begin
        mag_in[a] = pos_in[a];
      end
      lo_scaled[a] = QH_W'(prod[a][31:0]) * QH_W'(side);
      q_sum[a]     = {1'b0, q_hi[a]} + (QH_W + 1)'(q_lo[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (state == ST_IDLE && in_valid) begin
        mag[a] <= mag_in[a];
        neg[a] <= pos_in[a][POS_W-1];
      end
      if (state == ST_MUL) begin
        p_lo[a] <= PLO_W'(mag[a]) * PLO_W'(inv_box[16:0]);
        p_hi[a] <= PHI_W'(mag[a]) * PHI_W'(inv_box[INV_W-1:17]);
      end
      if (state == ST_SUM) begin
        prod[a] <= 64'(p_lo[a]) + {p_hi[a][46:0], 17'b0};
      end
      if (state == ST_SCALE) begin
        q_hi[a] <= QH_W'(prod[a][63:32]) * QH_W'(side);
        q_lo[a] <= lo_scaled[a][QH_W-1:32];
      end
      if (state == ST_CHECK) begin
        // Negative positions truncate towards zero, so only a zero quotient survives.
        if (neg[a]) begin
          ax_ok[a] <= (q_sum[a] == '0) && (side != '0);
          coord[a] <= '0;
        end else begin
          ax_ok[a] <= q_sum[a] < (QH_W + 1)'(side);
          coord[a] <= q_sum[a][CCW-1:0];
        end
      end
    end
    if (state == ST_IDLE && in_valid) begin
      op <= operation;
    end
  end

  assign item_ok = ax_ok[0] && ax_ok[1] && ax_ok[2];

  // ---- cell index and memories ----
  assign idx_comb = AW'(coord[2]) + AW'(side) * idx_part;

  always_ff @(posedge clk) begin
    if (state == ST_IDX1) begin
      idx_part <= AW'(coord[1]) + AW'(side) * AW'(coord[0]);
    end
    if (state == ST_IDX2) begin
      idx <= idx_comb;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[wr_addr] <= cnt_wdata;
    end
    if (fill_we) begin
      fill_mem[wr_addr] <= fill_wdata;
    end
    if (state == ST_IDX2) begin
      cnt_rd  <= count_mem[idx_comb];
      fill_rd <= fill_mem[idx_comb];
    end
  end

  // Saturating increments and capped indexes.
  assign cnt_inc     = (cnt_rd < CNT_MAX) ? cnt_rd + 1'b1 : CNT_MAX;
  assign fill_inc    = (fill_rd < CNT_MAX) ? fill_rd + 1'b1 : CNT_MAX;
  assign counted_inc = (counted_total < CNT_MAX) ? counted_total + 1'b1 : CNT_MAX;
  assign placed_inc  = (placed_total < CNT_MAX) ? placed_total + 1'b1 : CNT_MAX;
  assign slot_cap    = (fill_rd < CNT_MAX) ? fill_rd : IDX_MAX;
  assign placed_cap  = (placed_total < CNT_MAX) ? placed_total : IDX_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      counted_total <= '0;
      placed_total  <= '0;
    end else if (out_load && item_ok) begin
      if (op == OP_COUNT) begin
        counted_total <= counted_inc;
      end else begin
        placed_total <= placed_inc;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!item_ok) begin
        cell_index     <= '0;
        cell_count     <= '0;
        list_slot      <= '0;
        particle_index <= '0;
        total_counted  <= '0;
        out_of_range   <= 1'b1;
      end else if (op == OP_COUNT) begin
        cell_index     <= CIDX_W'(idx);
        cell_count     <= COUNT_W'(cnt_inc);
        list_slot      <= '0;
        particle_index <= '0;
        total_counted  <= COUNT_W'(counted_inc);
        out_of_range   <= 1'b0;
      end else begin
        cell_index     <= CIDX_W'(idx);
        cell_count     <= COUNT_W'(cnt_rd);
        list_slot      <= SLOT_W'(slot_cap);
        particle_index <= SLOT_W'(placed_cap);
        total_counted  <= COUNT_W'(counted_total);
        out_of_range   <= 1'b0;
      end
    end
  end

  // ---- assertions ----
  `ASSERT_CLK(a_dual_write_only_clearing, (cnt_we && fill_we) |-> (state == ST_CLEAR),
              "both cell memories written outside the clearing pass")
  `ASSERT_CLK(a_result_from_update, $rose(out_valid) |-> ($past(state) == ST_UPDATE),
              "result beat raised outside the update step")
  `ASSERT_CLK(a_skipped_item_clean, (out_valid && out_of_range) |->
              (cell_index == '0 && cell_count == '0 && list_slot == '0 &&
               particle_index == '0 && total_counted == '0),
              "skipped item carries non-zero fields")
  `ASSERT_NEVER(a_totals_saturate, (counted_total > CNT_MAX) || (placed_total > CNT_MAX),
                "particle total beyond its bound")

endmodule

### tb/sv/particle_cell_binning_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_cell_binning_top_test
// Self-checking bench for the two-pass particle cell binning block. A short
// table of directed particles runs first: extremes, wrap at the box edge,
// small and large negative positions, and both passes. After it come random
// count/place batches under several register settings, each with its own
// idling pattern. Every beat is checked field by field against its typed row
// or else an in-bench model of the cell counts, list fills and running totals.
// ---------------------------------------------------------------------------
module particle_cell_binning_top_test;
  import pcb_pkg::*;

  localparam int MAX_SIDE        = 16;
  localparam int MAX_PARTICLES   = 65536;
  localparam int NUM_CELLS       = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int RESET_CYCLES    = 12;
  localparam int TAIL_CYCLES     = 32;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TIMEOUT_CYCLES  = 1000000;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_DIRECTED    = 18;
  localparam int NUM_PHASES      = 8;

  typedef struct packed {
    logic [CIDX_W-1:0]  cell_index;
    logic [COUNT_W-1:0] cell_count;
    logic [SLOT_W-1:0]  list_slot;
    logic [SLOT_W-1:0]  particle_index;
    logic [COUNT_W-1:0] total_counted;
    logic               out_of_range;
  } bin_result_t;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             typed;
    bin_result_t      want;
  } directed_row_t;

  typedef struct packed {
    logic [BOX_W-1:0] box;
    logic [INV_W-1:0] inv;   // zero means derive it as 2^32 / box
    logic [CPS_W-1:0] side;
    logic [6:0]       sender_idle;
    logic [6:0]       recv_stall;
    logic [9:0]       items;
    logic             hold_off;
  } phase_t;

  localparam bin_result_t OUT_OF_GRID = '{12'd0, 17'd0, 16'd0, 16'd0, 17'd0, 1'b1};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_BOX_LENGTH;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     operation = OP_COUNT;
  logic signed [POS_W-1:0]  pos_x = '0;
  logic signed [POS_W-1:0]  pos_y = '0;
  logic signed [POS_W-1:0]  pos_z = '0;
  logic                     out_valid;
  logic                     out_ready;
  logic [CIDX_W-1:0]        cell_index;
  logic [COUNT_W-1:0]       cell_count;
  logic [SLOT_W-1:0]        list_slot;
  logic [SLOT_W-1:0]        particle_index;
  logic [COUNT_W-1:0]       total_counted;
  logic                     out_of_range;

  // Model copy of the registers and of the binning state.
  logic [BOX_W-1:0] box_len_cfg = BOX_LENGTH_RST;
  logic [INV_W-1:0] inv_box_cfg = INV_BOX_RST;
  logic [CPS_W-1:0] side_cfg    = CELLS_PER_SIDE_RST;
  int unsigned      cell_tally  [NUM_CELLS];
  int unsigned      cell_placed [NUM_CELLS];
  int unsigned      counted_sum = 0;
  int unsigned      placed_sum  = 0;

  bin_result_t   predicted_bins [$];
  bin_result_t   seen_bin;
  bin_result_t   due_bin;
  directed_row_t directed_rows [NUM_DIRECTED];
  phase_t        phases [NUM_PHASES];

  int unsigned sender_idle   = 0;
  int unsigned recv_stall    = 0;
  bit          hold_off_req  = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches    = 0;

  particle_cell_binning_top #(
    .MAX_SIDE      (MAX_SIDE),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_index     (cell_index),
    .cell_count     (cell_count),
    .list_slot      (list_slot),
    .particle_index (particle_index),
    .total_counted  (total_counted),
    .out_of_range   (out_of_range)
  );

  always #1 clk = ~clk;

  function automatic int unsigned sat_inc(input int unsigned v);
    return (v < MAX_PARTICLES) ? v + 1 : MAX_PARTICLES;
  endfunction

  function automatic int unsigned index_cap(input int unsigned v);
    return (v < MAX_PARTICLES) ? v : MAX_PARTICLES - 1;
  endfunction

  // Scales one coordinate into a cell coordinate. Negative positions are
  // truncated towards zero, so only those within one cell of the origin land.
  function automatic bit axis_to_cell(input logic [POS_W-1:0] coord, input int unsigned side,
                                      output int unsigned cell_coord);
    logic [POS_W-1:0] raw;
    logic [POS_W-1:0] neg_raw;
    logic [63:0]      mag;
    logic [63:0]      prod;
    logic [63:0]      q;
    bit               neg;
    raw  = coord;
    neg  = raw[POS_W-1];
    cell_coord = 0;
    if (raw == {1'b0, box_len_cfg}) raw = '0;
    neg_raw = ~raw + 1'b1;
    mag  = neg ? {32'b0, neg_raw} : {32'b0, raw};
    prod = mag * {31'b0, inv_box_cfg};
    q    = (prod >> 32) * side + (({32'b0, prod[31:0]} * side) >> 32);
    if (neg) return (q == 0) && (side != 0);
    if (q >= side) return 1'b0;
    cell_coord = q[31:0];
    return 1'b1;
  endfunction

  function automatic bin_result_t bin_particle(input logic op, input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y,
                                               input logic [POS_W-1:0] z);
    bin_result_t res;
    int unsigned side, cx, cy, cz, idx;
    bit          okx, oky, okz;
    res  = '0;
    side = (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
    okx  = axis_to_cell(x, side, cx);
    oky  = axis_to_cell(y, side, cy);
    okz  = axis_to_cell(z, side, cz);
    if (!(okx && oky && okz)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    idx = cz + side * (cy + side * cx);
    if (idx >= NUM_CELLS) idx = 0;
    if (op == OP_COUNT) begin
      cell_tally[idx] = sat_inc(cell_tally[idx]);
      counted_sum     = sat_inc(counted_sum);
      res.cell_count  = COUNT_W'(cell_tally[idx]);
    end else begin
      res.cell_count     = COUNT_W'(cell_tally[idx]);
      res.list_slot      = SLOT_W'(index_cap(cell_placed[idx]));
      res.particle_index = SLOT_W'(index_cap(placed_sum));
      cell_placed[idx]   = sat_inc(cell_placed[idx]);
      placed_sum         = sat_inc(placed_sum);
    end
    res.cell_index    = CIDX_W'(idx);
    res.total_counted = COUNT_W'(counted_sum);
    return res;
  endfunction

  // Mostly positions inside the box, some exactly on its edge, some negative
  // and some arbitrary words.
  function automatic logic [POS_W-1:0] pick_coord(input logic [BOX_W-1:0] box);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78) return POS_W'($urandom_range(0, box));
    if (r < 84) return {1'b0, box};
    if (r < 92) return ~POS_W'($urandom_range(0, box >> 3));
    return $urandom();
  endfunction

  task automatic write_config(input logic [BOX_W-1:0] box, input logic [INV_W-1:0] inv,
                              input logic [CPS_W-1:0] side);
    cfg_write <= 1'b1;
    cfg_index <= REG_BOX_LENGTH;
    cfg_data  <= CFG_W'(box);
    @(posedge clk);
    cfg_index <= REG_INV_BOX;
    cfg_data  <= CFG_W'(inv);
    @(posedge clk);
    cfg_index <= REG_CELLS_PER_SIDE;
    cfg_data  <= CFG_W'(side);
    @(posedge clk);
    cfg_write   <= 1'b0;
    box_len_cfg = box;
    inv_box_cfg = inv;
    side_cfg    = side;
  endtask

  // Offers one particle and holds it until the beat is taken. The previous
  // beat, if any, was accepted at the edge this task starts on.
  task automatic send_particle(input logic op, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                               input bit typed, input bin_result_t want);
    bin_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = bin_particle(op, x, y, z);
    predicted_bins.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Batches of particles go through the count pass and then the place pass,
  // with the odd stray beat or swapped pass mixed in.
  task automatic run_phase(input phase_t ph);
    logic [POS_W-1:0] bx [16];
    logic [POS_W-1:0] by [16];
    logic [POS_W-1:0] bz [16];
    logic             op;
    int unsigned      n;
    int unsigned      sent;
    sent = 0;
    while (sent < ph.items) begin
      n = $urandom_range(2, 12);
      for (int i = 0; i < n; i++) begin
        bx[i] = pick_coord(ph.box);
        by[i] = pick_coord(ph.box);
        bz[i] = pick_coord(ph.box);
      end
      for (int pass_no = 0; pass_no < 2; pass_no++) begin
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 99) < 8) begin
            send_particle(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                          1'b0, '0);
            sent++;
          end
          op = (pass_no == 0) ? OP_COUNT : OP_PLACE;
          if ($urandom_range(0, 99) < 5) op = ~op;
          send_particle(op, bx[i], by[i], bz[i], 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    end
  endtask

  // Result receiver: random stalls, and on request one long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_bin = {cell_index, cell_count, list_slot, particle_index, total_counted,
                  out_of_range};
      beats_checked++;
      if (predicted_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Result beat at %0t with nothing expected", $realtime);
      end else begin
        due_bin = predicted_bins.pop_front();
        check_field("cell_index", due_bin.cell_index, seen_bin.cell_index);
        check_field("cell_count", due_bin.cell_count, seen_bin.cell_count);
        check_field("list_slot", due_bin.list_slot, seen_bin.list_slot);
        check_field("particle_index", due_bin.particle_index, seen_bin.particle_index);
        check_field("total_counted", due_bin.total_counted, seen_bin.total_counted);
        check_field("out_of_range", due_bin.out_of_range, seen_bin.out_of_range);
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Timed out with %0d results outstanding", predicted_bins.size());
    $display("particle_cell_binning_top_test failed");
    $finish;
  end

  initial begin
    phase_t           ph;
    logic [INV_W-1:0] inv;

    // With the reset settings a cell is 4096 position units wide.
    directed_rows[0]  = '{OP_COUNT, 32'h0, 32'h0, 32'h0, 1'b1,
                          '{12'd0, 17'd1, 16'd0, 16'd0, 17'd1, 1'b0}};
    directed_rows[1]  = '{OP_COUNT, 32'h10000, 32'h10000, 32'h10000, 1'b1,
                          '{12'd0, 17'd2, 16'd0, 16'd0, 17'd2, 1'b0}};
    directed_rows[2]  = '{OP_COUNT, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b1,
                          '{12'd4095, 17'd1, 16'd0, 16'd0, 17'd3, 1'b0}};
    directed_rows[3]  = '{OP_PLACE, 32'h0, 32'h0, 32'h0, 1'b1,
                          '{12'd0, 17'd2, 16'd0, 16'd0, 17'd3, 1'b0}};
    directed_rows[4]  = '{OP_PLACE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                          '{12'd0, 17'd2, 16'd1, 16'd1, 17'd3, 1'b0}};
    directed_rows[5]  = '{OP_PLACE, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b1,
                          '{12'd4095, 17'd1, 16'd0, 16'd2, 17'd3, 1'b0}};
    directed_rows[6]  = '{OP_COUNT, 32'h10001, 32'h0, 32'h0, 1'b1, OUT_OF_GRID};
    directed_rows[7]  = '{OP_COUNT, 32'h0, 32'hFFFFF000, 32'h0, 1'b1, OUT_OF_GRID};
    directed_rows[8]  = '{OP_PLACE, 32'h0, 32'h0, 32'h80000000, 1'b1, OUT_OF_GRID};
    directed_rows[9]  = '{OP_COUNT, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1, OUT_OF_GRID};
    directed_rows[10] = '{OP_COUNT, 32'h1000, 32'h2000, 32'h3000, 1'b0, '0};
    directed_rows[11] = '{OP_COUNT, 32'hFFFFF001, 32'hFFF, 32'hF000, 1'b0, '0};
    directed_rows[12] = '{OP_PLACE, 32'h1000, 32'h2000, 32'h3000, 1'b0, '0};
    directed_rows[13] = '{OP_PLACE, 32'h3000, 32'h0, 32'h1000, 1'b0, '0};
    directed_rows[14] = '{OP_COUNT, 32'h55555555, 32'hAAAAAAAA, 32'h0, 1'b1, OUT_OF_GRID};
    directed_rows[15] = '{OP_COUNT, 32'hAAAA, 32'h5555, 32'hFFFF, 1'b0, '0};
    directed_rows[16] = '{OP_PLACE, 32'hAAAA, 32'h5555, 32'hFFFF, 1'b0, '0};
    directed_rows[17] = '{OP_COUNT, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1,
                          OUT_OF_GRID};

    phases[0] = '{31'd65536, 33'd65536, 5'd16, 7'd0, 7'd0, 10'd90, 1'b0};
    phases[1] = '{31'h7FFFFFFF, 33'd0, 5'd16, 7'd86, 7'd0, 10'd70, 1'b0};
    phases[2] = '{31'd1000, 33'd0, 5'd7, 7'd0, 7'd86, 10'd70, 1'b1};
    phases[3] = '{31'd1, 33'd0, 5'd1, 7'd25, 7'd25, 10'd30, 1'b0};
    phases[4] = '{31'd5000, 33'd0, 5'd31, 7'd25, 7'd25, 10'd70, 1'b0};
    phases[5] = '{31'd65536, 33'd1, 5'd0, 7'd0, 7'd0, 10'd20, 1'b0};
    phases[6] = '{31'd300, 33'd0, 5'd2, 7'd86, 7'd0, 10'd50, 1'b0};
    phases[7] = '{31'd0, 33'd0, 5'd0, 7'd0, 7'd86, 10'd70, 1'b0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed rows run on the reset register values; the clearing pass
    // simply holds off the first beat.
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_particle(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                    directed_rows[i].z, directed_rows[i].typed, directed_rows[i].want);
    in_valid <= 1'b0;
    while (predicted_bins.size() != 0) @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = phases[p];
      if (p == NUM_PHASES - 1) begin
        ph.box  = BOX_W'($urandom_range(2, 1 << 20));
        ph.side = CPS_W'($urandom_range(1, MAX_SIDE));
      end
      inv = (ph.inv != 0) ? ph.inv : INV_W'((64'd1 << 32) / ph.box);
      write_config(ph.box, inv, ph.side);
      sender_idle = ph.sender_idle;
      recv_stall  = ph.recv_stall;
      if (ph.hold_off) hold_off_req = 1'b1;
      run_phase(ph);
      in_valid <= 1'b0;
      // The block must be empty before the registers change.
      while (predicted_bins.size() != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d particles: directed rows, then count/place batches under %0d settings.",
             items_sent, NUM_PHASES);
    $display("Compared %0d result beats, %0d field mismatches, %0d results outstanding.",
             beats_checked, mismatches, predicted_bins.size());
    if (mismatches == 0 && predicted_bins.size() == 0) begin
      $display("particle_cell_binning_top_test passed");
    end else begin
      $display("particle_cell_binning_top_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pcb_pkg.sv
hdl/particle_cell_binning_top.sv
tb/sv/particle_cell_binning_top_test.sv
